>>> rtl/config_text_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// config_text_tokenizer_assert: assertion macros
// Implication checks sampled on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define CTT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("config_text_tokenizer: same-cycle check failed");

// next-cycle implication
`define CTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("config_text_tokenizer: next-cycle check failed");

`endif

>>> rtl/cttok_pkg.sv
// ----------------------------------------------------------------------------
// cttok_pkg: shared types, constants and helpers
// Scan modes, token kinds, result word and bundle types, byte classes.
// ----------------------------------------------------------------------------
package cttok_pkg;

  localparam int LINE_BITS = 16;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  localparam int MAX_ITEMS = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [7:0] {
    M_IDLE      = 8'b0000_0001,
    M_COMMENT   = 8'b0000_0010,
    M_NUMBER    = 8'b0000_0100,
    M_HEX       = 8'b0000_1000,
    M_WORD      = 8'b0001_0000,
    M_STRING    = 8'b0010_0000,
    M_CHAR      = 8'b0100_0000,
    M_CHARCLOSE = 8'b1000_0000
  } mode_t;

  typedef enum logic [3:0] {
    K_END       = 4'd0,
    K_NUMBER    = 4'd1,
    K_HEX       = 4'd2,
    K_COLON     = 4'd3,
    K_STRING    = 4'd4,
    K_CHARACTER = 4'd5,
    K_LBRACKET  = 4'd6,
    K_RBRACKET  = 4'd7,
    K_COMMA     = 4'd8,
    K_WORD      = 4'd9,
    K_ERROR     = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tbyte;
    logic        first;
    logic        last;
    logic        empty;
    logic [15:0] line;
  } item_t;

  // all result words caused by one text byte
  typedef struct packed {
    logic [1:0]                  count;
    item_t [MAX_ITEMS-1:0]       items;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } push_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] b);
    return b inside {[8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_word_end(input logic [7:0] b);
    return b inside {CH_QUOTE, CH_COLON, CH_LF, CH_TAB, CH_SPACE};
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
    return (l == LINE_MAX) ? l : l + LINE_ONE;
  endfunction

  // saturate the line count onto the 16-bit output field
  function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic kind_t mode_kind(input mode_t m);
    case (m)
      M_NUMBER: return K_NUMBER;
      M_HEX:    return K_HEX;
      M_STRING: return K_STRING;
      default:  return K_WORD;
    endcase
  endfunction

  function automatic item_t make_item(input kind_t k, input logic [7:0] b,
                                      input logic f, input logic l, input logic e,
                                      input logic [LINE_BITS-1:0] ln);
    item_t it;
    it.kind  = k;
    it.tbyte = b;
    it.first = f;
    it.last  = l;
    it.empty = e;
    it.line  = line_out(ln);
    return it;
  endfunction

  // closing word of an open multi-byte token
  function automatic item_t close_item(input mode_t m, input logic [7:0] hb,
                                       input logic hv, input logic hf,
                                       input logic [LINE_BITS-1:0] ln);
    return hv ? make_item(mode_kind(m), hb, hf, 1'b1, 1'b0, ln)
              : make_item(mode_kind(m), 8'h00, 1'b1, 1'b1, 1'b1, ln);
  endfunction

endpackage

>>> rtl/cttok_if.sv
// ----------------------------------------------------------------------------
// cttok_if: stream channels of the tokenizer
// Text byte channel in, token word channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface cttok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface cttok_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  token_byte;
  logic        token_first;
  logic        token_last;
  logic        token_empty;
  logic [15:0] line_number;
  logic        run_end;

  modport source (output valid, token_kind, token_byte, token_first, token_last,
                  token_empty, line_number, run_end, input ready);
  modport sink   (input valid, token_kind, token_byte, token_first, token_last,
                  token_empty, line_number, run_end, output ready);
endinterface

>>> rtl/cttok_front.sv
// ----------------------------------------------------------------------------
// cttok_front: byte classifier and scan state
// Takes one text byte a cycle unless the queue is full, updates the scan mode
// and line count, and builds the bundle of token words that the byte causes.
// ----------------------------------------------------------------------------
module cttok_front (
  input  logic                  clk,
  input  logic                  rst,
  cttok_in_if.sink              text,
  input  cttok_pkg::q_status_t  qs,
  output cttok_pkg::push_t      push
);

  cttok_pkg::mode_t                  scan_mode, scan_mode_next;
  logic [7:0]                        held_byte, held_byte_next;
  logic                              held_valid, held_valid_next;
  logic                              held_is_first, held_is_first_next;
  logic [cttok_pkg::LINE_BITS-1:0]   line_count, line_count_next;

  cttok_pkg::bundle_t bnd;
  logic               accept;

  assign text.ready = !qs.full;
  assign accept     = text.valid && text.ready;

  always_comb begin
    cttok_pkg::mode_t                m;
    logic [7:0]                      b;
    logic [7:0]                      hb;
    logic                            hv, hf, fin, fresh;
    logic [cttok_pkg::LINE_BITS-1:0] ln;
    logic [1:0]                      n;

    m     = scan_mode;
    hb    = held_byte;
    hv    = held_valid;
    hf    = held_is_first;
    ln    = line_count;
    b     = text.text_byte;
    fin   = text.end_of_text || (b == cttok_pkg::CH_NUL);
    fresh = 1'b0;
    n     = 2'd0;
    bnd   = '0;

    if (b != cttok_pkg::CH_NUL) begin
      case (m)
        cttok_pkg::M_COMMENT: begin
          if (b == cttok_pkg::CH_LF) begin
            ln = cttok_pkg::line_inc(ln);
            m  = cttok_pkg::M_IDLE;
          end
        end
        cttok_pkg::M_NUMBER, cttok_pkg::M_HEX: begin
          if (m == cttok_pkg::M_NUMBER && hf && b == cttok_pkg::CH_X) begin
            hb = cttok_pkg::CH_ZERO;
            m  = cttok_pkg::M_HEX;
          end else if (cttok_pkg::is_digit(b) || cttok_pkg::is_hex_letter(b)) begin
            bnd.items[n] = cttok_pkg::make_item(cttok_pkg::mode_kind(m), hb, hf,
                                                1'b0, 1'b0, ln);
            n  = n + 2'd1;
            hb = b;
            hv = 1'b1;
            hf = 1'b0;
          end else begin
            bnd.items[n] = cttok_pkg::close_item(m, hb, hv, hf, ln);
            n     = n + 2'd1;
            hb    = 8'h00;
            hv    = 1'b0;
            hf    = 1'b0;
            m     = cttok_pkg::M_IDLE;
            fresh = 1'b1;
          end
        end
        cttok_pkg::M_WORD, cttok_pkg::M_STRING: begin
          if (!cttok_pkg::is_word_end(b)) begin
            if (hv) begin
              bnd.items[n] = cttok_pkg::make_item(cttok_pkg::mode_kind(m), hb, hf,
                                                  1'b0, 1'b0, ln);
              n  = n + 2'd1;
              hf = 1'b0;
            end else begin
              hf = 1'b1;
            end
            hb = b;
            hv = 1'b1;
          end else begin
            // a closing quote of a string is consumed, other enders rescan
            fresh = !(m == cttok_pkg::M_STRING && b == cttok_pkg::CH_QUOTE);
            bnd.items[n] = cttok_pkg::close_item(m, hb, hv, hf, ln);
            n  = n + 2'd1;
            hb = 8'h00;
            hv = 1'b0;
            hf = 1'b0;
            m  = cttok_pkg::M_IDLE;
          end
        end
        cttok_pkg::M_CHAR: begin
          m = cttok_pkg::M_CHARCLOSE;
          bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_CHARACTER, b,
                                              1'b1, 1'b1, 1'b0, ln);
          n = n + 2'd1;
        end
        cttok_pkg::M_CHARCLOSE: begin
          m     = cttok_pkg::M_IDLE;
          fresh = (b != cttok_pkg::CH_APOS);
        end
        default: begin
          m     = cttok_pkg::M_IDLE;
          fresh = 1'b1;
        end
      endcase

      // byte seen between tokens
      if (fresh) begin
        if (cttok_pkg::is_digit(b)) begin
          m  = cttok_pkg::M_NUMBER;
          hb = b;
          hv = 1'b1;
          hf = 1'b1;
        end else begin
          case (b)
            cttok_pkg::CH_HASH:  m  = cttok_pkg::M_COMMENT;
            cttok_pkg::CH_LF:    ln = cttok_pkg::line_inc(ln);
            cttok_pkg::CH_TAB, cttok_pkg::CH_SPACE: begin
            end
            cttok_pkg::CH_COLON: begin
              bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_COLON, b,
                                                  1'b1, 1'b1, 1'b0, ln);
              n = n + 2'd1;
            end
            cttok_pkg::CH_LBRACK: begin
              bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_LBRACKET, b,
                                                  1'b1, 1'b1, 1'b0, ln);
              n = n + 2'd1;
            end
            cttok_pkg::CH_RBRACK: begin
              bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_RBRACKET, b,
                                                  1'b1, 1'b1, 1'b0, ln);
              n = n + 2'd1;
            end
            cttok_pkg::CH_COMMA: begin
              bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_COMMA, b,
                                                  1'b1, 1'b1, 1'b0, ln);
              n = n + 2'd1;
            end
            cttok_pkg::CH_QUOTE: begin
              m  = cttok_pkg::M_STRING;
              hv = 1'b0;
              hf = 1'b0;
            end
            cttok_pkg::CH_APOS: m = cttok_pkg::M_CHAR;
            default: begin
              if (b[7]) begin
                bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_ERROR, b,
                                                    1'b1, 1'b1, 1'b0, ln);
                n = n + 2'd1;
              end else begin
                m  = cttok_pkg::M_WORD;
                hb = b;
                hv = 1'b1;
                hf = 1'b1;
              end
            end
          endcase
        end
      end
    end

    // end of text: close what is open, then the end token, then reset
    if (fin) begin
      if (m == cttok_pkg::M_NUMBER || m == cttok_pkg::M_HEX ||
          m == cttok_pkg::M_WORD || m == cttok_pkg::M_STRING) begin
        bnd.items[n] = cttok_pkg::close_item(m, hb, hv, hf, ln);
        n = n + 2'd1;
      end else if (m == cttok_pkg::M_CHAR) begin
        bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_CHARACTER, 8'h00,
                                            1'b1, 1'b1, 1'b1, ln);
        n = n + 2'd1;
      end
      bnd.items[n] = cttok_pkg::make_item(cttok_pkg::K_END, 8'h00,
                                          1'b1, 1'b1, 1'b1, ln);
      n  = n + 2'd1;
      m  = cttok_pkg::M_IDLE;
      hb = 8'h00;
      hv = 1'b0;
      hf = 1'b0;
      ln = cttok_pkg::LINE_ONE;
    end

    bnd.count          = n;
    scan_mode_next     = m;
    held_byte_next     = hb;
    held_valid_next    = hv;
    held_is_first_next = hf;
    line_count_next    = ln;
  end

  assign push.valid = accept && (bnd.count != 2'd0);
  assign push.data  = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= cttok_pkg::M_IDLE;
      held_byte     <= 8'h00;
      held_valid    <= 1'b0;
      held_is_first <= 1'b0;
      line_count    <= cttok_pkg::LINE_ONE;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      held_is_first <= held_is_first_next;
      line_count    <= line_count_next;
    end
  end

endmodule

>>> rtl/cttok_queue.sv
// ----------------------------------------------------------------------------
// cttok_queue: bundle queue between classifier and emitter
// Small circular buffer of result bundles; one push and one pop a cycle.
// ----------------------------------------------------------------------------
module cttok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  cttok_pkg::push_t      push,
  input  logic                  pop,
  output cttok_pkg::bundle_t    head,
  output cttok_pkg::q_status_t  qs
);

  cttok_pkg::bundle_t               slots [cttok_pkg::QDEPTH];
  logic [cttok_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [cttok_pkg::QCNT_W-1:0]     count;
  logic                             do_push, do_pop;

  assign qs.valid = (count != '0);
  assign qs.full  = (count == cttok_pkg::QCNT_W'(cttok_pkg::QDEPTH));
  assign qs.count = count;
  assign head     = slots[rd_ptr];

  assign do_push = push.valid && !qs.full;
  assign do_pop  = pop && qs.valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + cttok_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + cttok_pkg::QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + cttok_pkg::QCNT_W'(1);
        2'b01:   count <= count - cttok_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/cttok_back.sv
// ----------------------------------------------------------------------------
// cttok_back: token word emitter
// Holds one bundle, hands out one word a cycle while ready, marks the last.
// ----------------------------------------------------------------------------
module cttok_back (
  input  logic                  clk,
  input  logic                  rst,
  input  cttok_pkg::bundle_t    head,
  input  cttok_pkg::q_status_t  qs,
  output logic                  pop,
  cttok_out_if.source           tokens
);

  cttok_pkg::bundle_t cur;
  logic               cur_valid;
  logic [1:0]         idx;
  cttok_pkg::item_t   item;
  logic               last_word, take, load;

  assign item      = cur.items[idx];
  assign last_word = (idx == cur.count - 2'd1);
  assign take      = tokens.valid && tokens.ready;
  assign load      = !cur_valid || (take && last_word);
  assign pop       = load && qs.valid;

  assign tokens.valid       = cur_valid;
  assign tokens.token_kind  = item.kind;
  assign tokens.token_byte  = item.tbyte;
  assign tokens.token_first = item.first;
  assign tokens.token_last  = item.last;
  assign tokens.token_empty = item.empty;
  assign tokens.line_number = item.line;
  assign tokens.run_end     = last_word;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= qs.valid;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

>>> rtl/config_text_tokenizer.sv
// ----------------------------------------------------------------------------
// config_text_tokenizer: streaming tokenizer for config text
// Text bytes in, tagged token words out, through a classifier, a bundle
// queue and an emitter.
// ----------------------------------------------------------------------------
// One text byte is taken every cycle while the four-bundle queue has room;
// the classifier settles scan mode, held byte and line count for that byte
// in the same cycle and queues the zero to three token words it causes. The
// emitter sends one token word a cycle while the sink is ready, so the
// sustained rate is one byte per cycle while bytes yield at most one word
// each, and one word per cycle otherwise (the output port sets the figure).
// The first word of a byte passes a queue slot and the emitter's bundle
// register before it is offered, and waits there while the emitter sends
// earlier words. A token's held byte goes out as a word when the next byte
// arrives, or in the closing word; run_end marks each byte's last word.
// A zero byte or end_of_text closes open tokens, adds an end token and
// returns the scan state to line one.
// ----------------------------------------------------------------------------
module config_text_tokenizer (
  input  logic         clk,
  input  logic         rst,
  cttok_in_if.sink     text,
  cttok_out_if.source  tokens
);

`include "config_text_tokenizer_assert.svh"

  cttok_pkg::push_t      push;      // classifier -> queue
  cttok_pkg::bundle_t    head;      // oldest queued bundle
  cttok_pkg::q_status_t  qs;        // queue fill state
  logic                  pop;       // emitter takes the head bundle

  // front: accepts and classifies bytes
  cttok_front u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .qs   (qs),
    .push (push)
  );

  // short queue so each side can stall on its own
  cttok_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .qs   (qs)
  );

  // back: serialises queued words onto the output channel
  cttok_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qs     (qs),
    .pop    (pop),
    .tokens (tokens)
  );

  // shape of an empty word, and of the end token
  logic empty_ok, end_ok;

  assign empty_ok = tokens.token_first && tokens.token_last &&
                    (tokens.token_byte == 8'h00);
  assign end_ok   = tokens.run_end && (tokens.line_number != 16'h0000);

  // queue never overfills, and a full queue blocks input
  `CTT_ASSERT_IMP(a_q_bound, 1'b1, qs.count <= cttok_pkg::QCNT_W'(cttok_pkg::QDEPTH))
  `CTT_ASSERT_IMP(a_full_stalls, qs.full, !text.ready)
  // an empty token is a single word with a zero byte
  `CTT_ASSERT_IMP(a_empty_word, tokens.valid && tokens.token_empty, empty_ok)
  // the end token always closes its byte's run
  `CTT_ASSERT_IMP(a_end_last, tokens.valid && (tokens.token_kind == cttok_pkg::K_END), end_ok)

endmodule
